// ----- hdl/dzv_pkg.sv -----
`default_nettype none
package dzv_pkg;

  localparam int DATA_W     = 64;
  localparam int BYTE_W     = 8;
  localparam int GROUP_W    = 7;
  localparam int MAX_BYTES  = 10;
  localparam int CNT_W      = 4;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;
  localparam int FIFO_CW    = 2;

  localparam logic [BYTE_W-1:0]  MORE_FLAG  = 8'h80;
  localparam logic [CNT_W-1:0]   LAST_IDX   = CNT_W'(MAX_BYTES - 1);
  localparam logic [FIFO_CW-1:0] FIFO_FULL  = FIFO_CW'(FIFO_DEPTH);

  typedef logic [DATA_W-1:0] word_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // (x << 1) xor (x >>> 63), shift wraps
  function automatic word_t zigzag(input word_t x);
    word_t fill;
    fill = {DATA_W{x[DATA_W-1]}};
    return {x[DATA_W-2:0], 1'b0} ^ fill;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/dzv_intf.sv -----
`default_nettype none
interface dzv_in_if;
  import dzv_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               list_start;

  modport source (output valid, output value, output list_start, input ready);
  modport sink   (input valid, input value, input list_start, output ready);
endinterface

interface dzv_out_if;
  import dzv_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              last_byte;

  modport source (output valid, output code_byte, output last_byte, input ready);
  modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/dzv_front.sv -----
`default_nettype none
module dzv_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  dzv_in_if.sink                  in_ch,
  input  wire dzv_pkg::fifo_stat_t q_stat,
  output logic                    q_push,
  output dzv_pkg::word_t          q_data
);
  import dzv_pkg::*;

  logic  delta_en_r;
  word_t prev_r;
  word_t raw;
  word_t coded;
  logic  accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign raw         = word_t'(in_ch.value);

  always_comb begin
    if (delta_en_r && !in_ch.list_start) begin
      coded = raw - prev_r;
    end else begin
      coded = raw;
    end
  end

  assign q_push = accept;
  assign q_data = zigzag(coded);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_en_r <= 1'b1;
      prev_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        delta_en_r <= cfg_wr_data;
      end
      if (accept) begin
        prev_r <= raw;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/dzv_fifo.sv -----
`default_nettype none
module dzv_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire dzv_pkg::word_t     wr_data,
  input  wire logic               pop,
  output dzv_pkg::word_t          rd_data,
  output dzv_pkg::fifo_stat_t     stat
);
  import dzv_pkg::*;

  word_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r;
  logic [FIFO_AW-1:0]  rd_ptr_r;
  logic [FIFO_CW-1:0]  cnt_r;
  logic                do_push;
  logic                do_pop;

  assign stat.full  = (cnt_r == FIFO_FULL);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/dzv_back.sv -----
`default_nettype none
module dzv_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dzv_pkg::fifo_stat_t q_stat,
  input  wire dzv_pkg::word_t     q_data,
  output logic                    q_pop,
  dzv_out_if.source               out_ch
);
  import dzv_pkg::*;

  word_t             work_r, work_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;

  logic              can_load;
  word_t             src;
  logic [CNT_W-1:0]  src_cnt;
  logic              emit;
  logic              fin;

  assign out_ch.valid     = ovalid_r;
  assign out_ch.code_byte = obyte_r;
  assign out_ch.last_byte = olast_r;

  assign can_load = !ovalid_r || out_ch.ready;

  always_comb begin
    // continue the current value first, else start the next one from the queue
    src     = busy_r ? work_r : q_data;
    src_cnt = busy_r ? cnt_r : '0;
    emit    = can_load && (busy_r || !q_stat.empty);
    q_pop   = can_load && !busy_r && !q_stat.empty;
    fin     = (src[DATA_W-1:GROUP_W] == '0) || (src_cnt == LAST_IDX);

    work_nxt   = work_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;

    if (can_load) begin
      ovalid_nxt = emit;
      if (emit) begin
        obyte_nxt = fin ? src[BYTE_W-1:0] : (MORE_FLAG | {1'b0, src[GROUP_W-1:0]});
        olast_nxt = fin;
        work_nxt  = src >> GROUP_W;
        cnt_nxt   = src_cnt + 1'b1;
        busy_nxt  = !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    cnt_r   <= cnt_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/delta_zigzag_varint_encoder.sv -----
`default_nettype none
// delta / zigzag / varint encoder. each input beat carries a signed 64-bit
// value and a list_start flag; with delta_enable set (reset value), a value
// that does not start a list is replaced by its wrapping difference from the
// previous input value (zero after reset). the result is zigzag mapped and
// sent low 7-bit group first, one output beat per byte, 1 to 10 beats per
// value, bit 7 set on every byte but the last and last_byte marking the end.
// the byte serializer emits one byte per cycle while out_ch.ready is high
// and starts the next value from the queue once the previous one's last
// byte is registered, so values follow with no idle cycle while the queue
// is not empty; an accepted beat passes through the queue and the output
// byte register before its first byte shows. the front stage takes a beat
// per cycle while the two-entry queue has room.
// cfg_wr_en/cfg_wr_data write delta_enable; write only while the block is idle.
module delta_zigzag_varint_encoder (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  dzv_in_if.sink    in_ch,
  dzv_out_if.source out_ch
);
  import dzv_pkg::*;

  // front to queue
  logic       q_push;
  word_t      q_wr_data;
  // queue to back
  logic       q_pop;
  word_t      q_rd_data;
  fifo_stat_t q_stat;

  // subtract and zigzag map in the front
  dzv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  // mapped values wait here so each side stalls on its own
  dzv_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  // byte serializer with registered output
  dzv_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_data (q_rd_data),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
